/* sv/pidpc_pkg.sv */
`default_nettype none
package pidpc_pkg;

    // Fraction bits of every Q-format value.
    localparam int FRAC_BITS = 32;
    localparam int DW        = 64;
    localparam int CW        = 63;
    localparam int IDXW      = 3;

    localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MIN_NEG = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [IDXW-1:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I_DT   = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_FORCE_LIMIT = 3'd3,
        REG_PC_ENABLE   = 3'd4
    } reg_idx_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_LATCH, ST_POS, ST_VEL,
        ST_P_ERR, ST_P_MI, ST_P_INTEG, ST_P_MP, ST_P_PSAVE, ST_P_DERR, ST_P_MD,
        ST_P_DADD, ST_P_IADD,
        ST_M_MUL, ST_M_TAKE, ST_M_CHK, ST_M_RESTORE, ST_M_NUM, ST_M_DIV, ST_M_NEWV,
        ST_M_FMUL, ST_M_FIN,
        ST_E_MM, ST_E_ACCM, ST_E_MS, ST_E_ACCS,
        ST_S_FK, ST_S_MUL, ST_S_TAKE, ST_S_CHK, ST_S_RESTORE, ST_S_NUM, ST_S_DIV,
        ST_S_NEWF, ST_S_FMUL, ST_S_FIN,
        ST_OUT, ST_WAIT_MUL, ST_WAIT_DIV
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_LATCH, OP_POS, OP_VEL,
        OP_ERR, OP_INTEG, OP_PSAVE, OP_DERR, OP_DADD, OP_IADD,
        OP_MTAKE, OP_MCHK, OP_MRESTORE, OP_MNUM, OP_MNEWV, OP_MFIN,
        OP_ACCM, OP_ACCS,
        OP_FK, OP_STAKE, OP_SCHK, OP_SRESTORE, OP_SNUM, OP_SNEWF, OP_SFIN,
        OP_TOTAL
    } op_t;

    typedef enum logic [2:0] {
        MS_I_ERR, MS_P_ERR, MS_D_DERR, MS_F1_HMV, MS_HMF_VEL, MS_VEL_HSF, MS_FK_VEL
    } msel_t;

    typedef enum logic {
        DS_MASTER, DS_SLAVE
    } dsel_t;

    typedef struct packed {
        op_t   op;
        logic  mul_start;
        msel_t msel;
        logic  div_start;
        dsel_t dsel;
    } cmd_t;

    typedef struct packed {
        logic first;
        logic mul_done;
        logic div_done;
        logic mfire;
        logic sfire;
        logic out_busy;
    } stat_t;

    typedef struct packed {
        logic [CW-1:0] gain_p;
        logic [CW-1:0] gain_i_dt;
        logic [CW-1:0] gain_d;
        logic [CW-1:0] force_limit;
        logic          pc_enable;
    } cfg_t;

    function automatic logic [DW-1:0] sadd(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? MIN_NEG : MAX_POS;
        end
        return s[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] ssub(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? MIN_NEG : MAX_POS;
        end
        return s[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] mag(input logic [DW-1:0] a);
        return a[DW-1] ? (DW'(0) - a) : a;
    endfunction

    // Saturating signed value from a sign and a magnitude; big flags overflow past 64 bits.
    function automatic logic [DW-1:0] from_mag(input logic neg, input logic big,
                                               input logic [DW-1:0] m);
        if (!neg) begin
            return (big || m[DW-1]) ? MAX_POS : m;
        end
        if (big || m[DW-1]) begin
            return MIN_NEG;
        end
        return DW'(0) - m;
    endfunction

endpackage
`default_nettype wire

/* sv/pidpc_mul.sv */
`default_nettype none
// Fixed-point multiplier: four 32x32 partial products, then round and saturate.
module pidpc_mul (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      result
);
    logic [63:0]  x_reg, y_reg;
    logic         neg_reg;
    logic [127:0] acc_reg, acc_next;
    logic [2:0]   step_reg;
    logic         busy_reg, done_reg;
    logic [63:0]  res_reg, res_next;
    logic [31:0]  xs, ys;
    logic [63:0]  pp;
    logic [127:0] q, q1;

    always_comb begin
        xs = step_reg[0] ? x_reg[63:32] : x_reg[31:0];
        ys = step_reg[1] ? y_reg[63:32] : y_reg[31:0];
        pp = 64'(xs) * 64'(ys);
        case (step_reg[1:0])
            2'd0:    acc_next = acc_reg + {64'd0, pp};
            2'd3:    acc_next = acc_reg + {pp, 64'd0};
            default: acc_next = acc_reg + {32'd0, pp, 32'd0};
        endcase
        q        = acc_reg >> pidpc_pkg::FRAC_BITS;
        q1       = q + 128'(neg_reg && (acc_reg[pidpc_pkg::FRAC_BITS-1:0] != '0));
        res_next = pidpc_pkg::from_mag(neg_reg, q1[127:64] != '0, q1[63:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            if (start) begin
                x_reg    <= pidpc_pkg::mag(a);
                y_reg    <= pidpc_pkg::mag(b);
                neg_reg  <= a[63] ^ b[63];
                acc_reg  <= '0;
                step_reg <= '0;
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end else if (busy_reg) begin
                if (step_reg == 3'd4) begin
                    res_reg  <= res_next;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    acc_reg  <= acc_next;
                    step_reg <= step_reg + 3'd1;
                    done_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule
`default_nettype wire

/* sv/pidpc_div.sv */
`default_nettype none
// Fixed-point divider: restoring division, one quotient bit per cycle.
module pidpc_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      result
);
    logic [127:0] num_reg;
    logic [63:0]  d_reg, rem_reg, q_reg, res_reg;
    logic         neg_reg, big_reg, busy_reg, fin_reg, done_reg;
    logic [6:0]   cnt_reg;
    logic [64:0]  r2, r2s;
    logic         ge;

    always_comb begin
        r2  = {rem_reg, num_reg[127]};
        r2s = r2 - {1'b0, d_reg};
        ge  = (r2 >= {1'b0, d_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            if (start) begin
                if (b == '0) begin
                    res_reg  <= '0;
                    done_reg <= 1'b1;
                end else begin
                    d_reg    <= pidpc_pkg::mag(b);
                    num_reg  <= {64'd0, pidpc_pkg::mag(a)} << pidpc_pkg::FRAC_BITS;
                    rem_reg  <= '0;
                    q_reg    <= '0;
                    big_reg  <= 1'b0;
                    neg_reg  <= a[63] ^ b[63];
                    cnt_reg  <= '0;
                    busy_reg <= 1'b1;
                    done_reg <= 1'b0;
                end
            end else if (fin_reg) begin
                res_reg  <= pidpc_pkg::from_mag(neg_reg, big_reg, q_reg);
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end else if (busy_reg) begin
                done_reg <= 1'b0;
                rem_reg <= ge ? r2s[63:0] : r2[63:0];
                num_reg <= {num_reg[126:0], 1'b0};
                // The upper half of the quotient only ever signals overflow.
                if (ge && !cnt_reg[6]) begin
                    big_reg <= 1'b1;
                end
                q_reg   <= {q_reg[62:0], ge & cnt_reg[6]};
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd127) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule
`default_nettype wire

/* sv/pidpc_ctrl.sv */
`default_nettype none
// Sequencer: issues at most one datapath operation per state and waits on the shared units.
module pidpc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire pidpc_pkg::stat_t  stat,
    output pidpc_pkg::cmd_t        cmd
);
    pidpc_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic pid2_reg, pid2_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pidpc_pkg::ST_IDLE;
            ret_reg   <= pidpc_pkg::ST_IDLE;
            pid2_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            pid2_reg  <= pid2_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        pid2_next     = pid2_reg;
        cmd.op        = pidpc_pkg::OP_NONE;
        cmd.mul_start = 1'b0;
        cmd.msel      = pidpc_pkg::MS_I_ERR;
        cmd.div_start = 1'b0;
        cmd.dsel      = pidpc_pkg::DS_MASTER;
        in_ready      = 1'b0;
        unique case (state_reg)
            pidpc_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.op     = pidpc_pkg::OP_LOAD;
                    state_next = pidpc_pkg::ST_LATCH;
                end
            end
            pidpc_pkg::ST_LATCH: begin
                cmd.op     = pidpc_pkg::OP_LATCH;
                pid2_next  = 1'b0;
                state_next = stat.first ? pidpc_pkg::ST_IDLE : pidpc_pkg::ST_POS;
            end
            pidpc_pkg::ST_POS: begin
                cmd.op = pidpc_pkg::OP_POS;  state_next = pidpc_pkg::ST_VEL;
            end
            pidpc_pkg::ST_VEL: begin
                cmd.op = pidpc_pkg::OP_VEL;  state_next = pidpc_pkg::ST_P_ERR;
            end
            pidpc_pkg::ST_P_ERR: begin
                cmd.op = pidpc_pkg::OP_ERR;  state_next = pidpc_pkg::ST_P_MI;
            end
            pidpc_pkg::ST_P_MI: begin
                cmd.mul_start = 1'b1;  cmd.msel = pidpc_pkg::MS_I_ERR;
                ret_next = pidpc_pkg::ST_P_INTEG;  state_next = pidpc_pkg::ST_WAIT_MUL;
            end
            pidpc_pkg::ST_P_INTEG: begin
                cmd.op = pidpc_pkg::OP_INTEG;  state_next = pidpc_pkg::ST_P_MP;
            end
            pidpc_pkg::ST_P_MP: begin
                cmd.mul_start = 1'b1;  cmd.msel = pidpc_pkg::MS_P_ERR;
                ret_next = pidpc_pkg::ST_P_PSAVE;  state_next = pidpc_pkg::ST_WAIT_MUL;
            end
            pidpc_pkg::ST_P_PSAVE: begin
                cmd.op = pidpc_pkg::OP_PSAVE;  state_next = pidpc_pkg::ST_P_DERR;
            end
            pidpc_pkg::ST_P_DERR: begin
                cmd.op = pidpc_pkg::OP_DERR;  state_next = pidpc_pkg::ST_P_MD;
            end
            pidpc_pkg::ST_P_MD: begin
                cmd.mul_start = 1'b1;  cmd.msel = pidpc_pkg::MS_D_DERR;
                ret_next = pidpc_pkg::ST_P_DADD;  state_next = pidpc_pkg::ST_WAIT_MUL;
            end
            pidpc_pkg::ST_P_DADD: begin
                cmd.op = pidpc_pkg::OP_DADD;  state_next = pidpc_pkg::ST_P_IADD;
            end
            pidpc_pkg::ST_P_IADD: begin
                cmd.op     = pidpc_pkg::OP_IADD;
                state_next = pid2_reg ? pidpc_pkg::ST_M_FMUL : pidpc_pkg::ST_M_MUL;
            end
            pidpc_pkg::ST_M_MUL: begin
                cmd.mul_start = 1'b1;  cmd.msel = pidpc_pkg::MS_F1_HMV;
                ret_next = pidpc_pkg::ST_M_TAKE;  state_next = pidpc_pkg::ST_WAIT_MUL;
            end
            pidpc_pkg::ST_M_TAKE: begin
                cmd.op = pidpc_pkg::OP_MTAKE;  state_next = pidpc_pkg::ST_M_CHK;
            end
            pidpc_pkg::ST_M_CHK: begin
                cmd.op     = pidpc_pkg::OP_MCHK;
                state_next = stat.mfire ? pidpc_pkg::ST_M_RESTORE : pidpc_pkg::ST_E_MM;
            end
            pidpc_pkg::ST_M_RESTORE: begin
                cmd.op = pidpc_pkg::OP_MRESTORE;  state_next = pidpc_pkg::ST_M_NUM;
            end
            pidpc_pkg::ST_M_NUM: begin
                cmd.op = pidpc_pkg::OP_MNUM;  state_next = pidpc_pkg::ST_M_DIV;
            end
            pidpc_pkg::ST_M_DIV: begin
                cmd.div_start = 1'b1;  cmd.dsel = pidpc_pkg::DS_MASTER;
                ret_next = pidpc_pkg::ST_M_NEWV;  state_next = pidpc_pkg::ST_WAIT_DIV;
            end
            pidpc_pkg::ST_M_NEWV: begin
                cmd.op     = pidpc_pkg::OP_MNEWV;
                pid2_next  = 1'b1;
                state_next = pidpc_pkg::ST_P_ERR;
            end
            pidpc_pkg::ST_M_FMUL: begin
                cmd.mul_start = 1'b1;  cmd.msel = pidpc_pkg::MS_F1_HMV;
                ret_next = pidpc_pkg::ST_M_FIN;  state_next = pidpc_pkg::ST_WAIT_MUL;
            end
            pidpc_pkg::ST_M_FIN: begin
                cmd.op = pidpc_pkg::OP_MFIN;  state_next = pidpc_pkg::ST_E_MM;
            end
            pidpc_pkg::ST_E_MM: begin
                cmd.mul_start = 1'b1;  cmd.msel = pidpc_pkg::MS_HMF_VEL;
                ret_next = pidpc_pkg::ST_E_ACCM;  state_next = pidpc_pkg::ST_WAIT_MUL;
            end
            pidpc_pkg::ST_E_ACCM: begin
                cmd.op = pidpc_pkg::OP_ACCM;  state_next = pidpc_pkg::ST_E_MS;
            end
            pidpc_pkg::ST_E_MS: begin
                cmd.mul_start = 1'b1;  cmd.msel = pidpc_pkg::MS_VEL_HSF;
                ret_next = pidpc_pkg::ST_E_ACCS;  state_next = pidpc_pkg::ST_WAIT_MUL;
            end
            pidpc_pkg::ST_E_ACCS: begin
                cmd.op = pidpc_pkg::OP_ACCS;  state_next = pidpc_pkg::ST_S_FK;
            end
            pidpc_pkg::ST_S_FK: begin
                cmd.op = pidpc_pkg::OP_FK;  state_next = pidpc_pkg::ST_S_MUL;
            end
            pidpc_pkg::ST_S_MUL: begin
                cmd.mul_start = 1'b1;  cmd.msel = pidpc_pkg::MS_FK_VEL;
                ret_next = pidpc_pkg::ST_S_TAKE;  state_next = pidpc_pkg::ST_WAIT_MUL;
            end
            pidpc_pkg::ST_S_TAKE: begin
                cmd.op = pidpc_pkg::OP_STAKE;  state_next = pidpc_pkg::ST_S_CHK;
            end
            pidpc_pkg::ST_S_CHK: begin
                cmd.op     = pidpc_pkg::OP_SCHK;
                state_next = stat.sfire ? pidpc_pkg::ST_S_RESTORE : pidpc_pkg::ST_OUT;
            end
            pidpc_pkg::ST_S_RESTORE: begin
                cmd.op = pidpc_pkg::OP_SRESTORE;  state_next = pidpc_pkg::ST_S_NUM;
            end
            pidpc_pkg::ST_S_NUM: begin
                cmd.op = pidpc_pkg::OP_SNUM;  state_next = pidpc_pkg::ST_S_DIV;
            end
            pidpc_pkg::ST_S_DIV: begin
                cmd.div_start = 1'b1;  cmd.dsel = pidpc_pkg::DS_SLAVE;
                ret_next = pidpc_pkg::ST_S_NEWF;  state_next = pidpc_pkg::ST_WAIT_DIV;
            end
            pidpc_pkg::ST_S_NEWF: begin
                cmd.op = pidpc_pkg::OP_SNEWF;  state_next = pidpc_pkg::ST_S_FMUL;
            end
            pidpc_pkg::ST_S_FMUL: begin
                cmd.mul_start = 1'b1;  cmd.msel = pidpc_pkg::MS_FK_VEL;
                ret_next = pidpc_pkg::ST_S_FIN;  state_next = pidpc_pkg::ST_WAIT_MUL;
            end
            pidpc_pkg::ST_S_FIN: begin
                cmd.op = pidpc_pkg::OP_SFIN;  state_next = pidpc_pkg::ST_OUT;
            end
            pidpc_pkg::ST_OUT: begin
                if (!stat.out_busy) begin
                    cmd.op     = pidpc_pkg::OP_TOTAL;
                    state_next = pidpc_pkg::ST_IDLE;
                end
            end
            pidpc_pkg::ST_WAIT_MUL: begin
                if (stat.mul_done) begin
                    state_next = ret_reg;
                end
            end
            pidpc_pkg::ST_WAIT_DIV: begin
                if (stat.div_done) begin
                    state_next = ret_reg;
                end
            end
            default: state_next = pidpc_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* sv/pidpc_dp.sv */
`default_nettype none
// Datapath: tick state, scratch registers, shared multiplier and divider, result register.
module pidpc_dp (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pidpc_pkg::cmd_t   cmd,
    input  wire pidpc_pkg::cfg_t   cfg,
    output pidpc_pkg::stat_t       stat,
    input  wire logic [447:0]      in_data,
    input  wire logic [1:0]        in_flags,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [319:0]           out_data,
    output logic [1:0]             out_flags
);
    logic [63:0] pos_reg, imv_reg, imf_reg, ime_reg, isf_reg, isc_reg, ise_reg;
    logic [1:0]  iflag_reg;
    logic        first_reg;
    logic [63:0] origin_reg, rel_reg, ref_reg, prev_reg;
    logic [63:0] hmv_reg, hmf_reg, hme_reg, mne_reg;
    logic [63:0] hsf_reg, hsc_reg, hse_reg, sne_reg;
    logic [63:0] integ_reg, perr_reg, accm_reg, accs_reg;
    logic [63:0] vel_reg, err_reg, derr_reg, acc_reg, f1_reg, fk_reg, taken_reg, num_reg;
    logic        mfired_reg, sfired_reg, ovalid_reg;
    logic [319:0] odata_reg;
    logic [1:0]  oflag_reg;

    logic [63:0] mul_a, mul_b, mul_res, div_res, div_b, p_take;
    logic        mul_done, div_done;
    logic [63:0] total, lim, nlim, msum, ssum;

    always_comb begin
        unique case (cmd.msel)
            pidpc_pkg::MS_I_ERR:   begin mul_a = {1'b0, cfg.gain_i_dt}; mul_b = err_reg;  end
            pidpc_pkg::MS_P_ERR:   begin mul_a = {1'b0, cfg.gain_p};    mul_b = err_reg;  end
            pidpc_pkg::MS_D_DERR:  begin mul_a = {1'b0, cfg.gain_d};    mul_b = derr_reg; end
            pidpc_pkg::MS_F1_HMV:  begin mul_a = f1_reg;  mul_b = hmv_reg; end
            pidpc_pkg::MS_HMF_VEL: begin mul_a = hmf_reg; mul_b = vel_reg; end
            pidpc_pkg::MS_VEL_HSF: begin mul_a = vel_reg; mul_b = hsf_reg; end
            pidpc_pkg::MS_FK_VEL:  begin mul_a = fk_reg;  mul_b = vel_reg; end
            default:               begin mul_a = '0;      mul_b = '0;      end
        endcase
        div_b  = (cmd.dsel == pidpc_pkg::DS_SLAVE) ? vel_reg : f1_reg;
        p_take = (!mul_res[63] && mul_res != '0) ? mul_res : '0;
        msum   = pidpc_pkg::sadd(hme_reg, mne_reg);
        ssum   = pidpc_pkg::sadd(hse_reg, sne_reg);
        lim    = {1'b0, cfg.force_limit};
        nlim   = 64'd0 - lim;
        total  = pidpc_pkg::sadd(f1_reg, fk_reg);
        if ($signed(total) < $signed(nlim)) begin
            total = nlim;
        end
        if ($signed(total) > $signed(lim)) begin
            total = lim;
        end
    end

    pidpc_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .result(mul_res)
    );

    pidpc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .a(num_reg), .b(div_b), .done(div_done), .result(div_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg  <= 1'b1;
            origin_reg <= '0;  rel_reg  <= '0;  ref_reg  <= '0;
            hmv_reg    <= '0;  hmf_reg  <= '0;  hme_reg  <= '0;  mne_reg <= '0;
            hsf_reg    <= '0;  hsc_reg  <= '0;  hse_reg  <= '0;  sne_reg <= '0;
            integ_reg  <= '0;  perr_reg <= '0;  accm_reg <= '0;  accs_reg <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            if (ovalid_reg && out_ready && cmd.op != pidpc_pkg::OP_TOTAL) begin
                ovalid_reg <= 1'b0;
            end
            case (cmd.op)
                pidpc_pkg::OP_LOAD: begin
                    pos_reg <= in_data[63:0];
                    imv_reg <= in_data[127:64];
                    imf_reg <= in_data[191:128];
                    ime_reg <= in_data[255:192];
                    isf_reg <= in_data[319:256];
                    isc_reg <= in_data[383:320];
                    ise_reg <= in_data[447:384];
                    iflag_reg <= in_flags;
                end
                pidpc_pkg::OP_LATCH: begin
                    if (iflag_reg[0]) begin
                        hmv_reg <= imv_reg;
                        ref_reg <= pidpc_pkg::sadd(ref_reg, imv_reg);
                        hmf_reg <= imf_reg;
                        hme_reg <= ime_reg;
                    end
                    if (iflag_reg[1]) begin
                        hsf_reg <= isf_reg;
                        hsc_reg <= isc_reg;
                        hse_reg <= ise_reg;
                    end
                    prev_reg   <= rel_reg;
                    mfired_reg <= 1'b0;
                    sfired_reg <= 1'b0;
                    if (first_reg) begin
                        origin_reg <= pos_reg;
                        first_reg  <= 1'b0;
                    end
                end
                pidpc_pkg::OP_POS:   rel_reg   <= pidpc_pkg::ssub(pos_reg, origin_reg);
                pidpc_pkg::OP_VEL:   vel_reg   <= pidpc_pkg::ssub(rel_reg, prev_reg);
                pidpc_pkg::OP_ERR:   err_reg   <= pidpc_pkg::ssub(ref_reg, rel_reg);
                pidpc_pkg::OP_INTEG: integ_reg <= pidpc_pkg::sadd(integ_reg, mul_res);
                pidpc_pkg::OP_PSAVE: acc_reg   <= mul_res;
                pidpc_pkg::OP_DERR:  derr_reg  <= pidpc_pkg::ssub(err_reg, perr_reg);
                pidpc_pkg::OP_DADD:  acc_reg   <= pidpc_pkg::sadd(acc_reg, mul_res);
                pidpc_pkg::OP_IADD: begin
                    f1_reg   <= pidpc_pkg::sadd(acc_reg, integ_reg);
                    perr_reg <= err_reg;
                end
                pidpc_pkg::OP_MTAKE: begin
                    taken_reg <= p_take;
                    mne_reg   <= pidpc_pkg::ssub(mne_reg, p_take);
                end
                pidpc_pkg::OP_MCHK:  mfired_reg <= stat.mfire;
                pidpc_pkg::OP_MRESTORE: begin
                    mne_reg <= pidpc_pkg::sadd(mne_reg, taken_reg);
                    ref_reg <= pidpc_pkg::ssub(ref_reg, hmv_reg);
                end
                pidpc_pkg::OP_MNUM:  num_reg <= msum;
                pidpc_pkg::OP_MNEWV: begin
                    hmv_reg <= div_res;
                    ref_reg <= pidpc_pkg::sadd(ref_reg, div_res);
                end
                pidpc_pkg::OP_MFIN:  mne_reg <= pidpc_pkg::ssub(mne_reg, mul_res);
                pidpc_pkg::OP_ACCM: begin
                    if (!mul_res[63] && mul_res != '0) begin
                        accm_reg <= pidpc_pkg::sadd(accm_reg, mul_res);
                    end
                end
                pidpc_pkg::OP_ACCS: begin
                    if (!mul_res[63] && mul_res != '0) begin
                        accs_reg <= pidpc_pkg::sadd(accs_reg, mul_res);
                    end
                end
                pidpc_pkg::OP_FK:    fk_reg <= hsc_reg;
                pidpc_pkg::OP_STAKE: begin
                    taken_reg <= p_take;
                    sne_reg   <= pidpc_pkg::ssub(sne_reg, p_take);
                end
                pidpc_pkg::OP_SCHK:     sfired_reg <= stat.sfire;
                pidpc_pkg::OP_SRESTORE: sne_reg <= pidpc_pkg::sadd(sne_reg, taken_reg);
                pidpc_pkg::OP_SNUM:     num_reg <= ssum;
                pidpc_pkg::OP_SNEWF: begin
                    fk_reg  <= div_res;
                    hsc_reg <= div_res;
                end
                pidpc_pkg::OP_SFIN:  sne_reg <= pidpc_pkg::ssub(sne_reg, mul_res);
                pidpc_pkg::OP_TOTAL: begin
                    odata_reg  <= {accs_reg, accm_reg, vel_reg, f1_reg, total};
                    oflag_reg  <= {sfired_reg, mfired_reg};
                    ovalid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        stat.first    = first_reg;
        stat.mul_done = mul_done;
        stat.div_done = div_done;
        stat.mfire    = cfg.pc_enable & msum[63];
        stat.sfire    = ssum[63];
        stat.out_busy = ovalid_reg & ~out_ready;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_flags = oflag_reg;
endmodule
`default_nettype wire

/* sv/pid_passivity_force_controller_unit.sv */
`default_nettype none
// Channel     | Direction | Handshake          | Contents
// s_ (input)  | in        | s_tvalid/s_tready  | one servo tick: position and newest messages
// m_ (result) | out       | m_tvalid/m_tready  | force command, coupling force, velocity, energies
// cfg_        | in        | cfg_wr_en          | gains, force limit and correction enable
//
// A transaction is taken only while the sequencer is idle; a tick then runs the latch,
// position, velocity and PID steps, master check, energy sums and slave check, with 7 products
// (each: issue state, four partial products, rounding, done pulse). A master correction adds
// a division, a second PID pass and one more product, a slave correction a division and one
// more product; a zero divisor skips the division loop and gives zero. The very first tick
// after reset runs only the latch step and produces no result transaction.
// Reset is synchronous and active low. A result waits in the output register while
// the next tick is accepted; the sequencer stalls only when a new result is ready
// and the previous one has still not been taken.
module pid_passivity_force_controller_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // Fields from bit 0: position_sample, master_velocity, master_force,
    // master_energy_in, slave_force, slave_coupling_force, slave_energy_in.
    input  wire logic [447:0] s_tdata,
    // Fields from bit 0: master_msg_valid, slave_msg_valid.
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // Fields from bit 0: force_command, coupling_force, local_velocity,
    // energy_to_master, energy_to_slave.
    output logic [319:0]      m_tdata,
    // Fields from bit 0: master_pc_fired, slave_pc_fired.
    output logic [1:0]        m_tuser,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [62:0]  cfg_wdata
);
    pidpc_pkg::cfg_t  cfg_reg;
    pidpc_pkg::cmd_t  cmd;
    pidpc_pkg::stat_t stat;

    // Configuration registers; writes to indexes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p      <= 63'd858993459;
            cfg_reg.gain_i_dt   <= 63'd4295;
            cfg_reg.gain_d      <= 63'd4294967296;
            cfg_reg.force_limit <= 63'd21474836480;
            cfg_reg.pc_enable   <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pidpc_pkg::REG_GAIN_P:      cfg_reg.gain_p      <= cfg_wdata;
                pidpc_pkg::REG_GAIN_I_DT:   cfg_reg.gain_i_dt   <= cfg_wdata;
                pidpc_pkg::REG_GAIN_D:      cfg_reg.gain_d      <= cfg_wdata;
                pidpc_pkg::REG_FORCE_LIMIT: cfg_reg.force_limit <= cfg_wdata;
                pidpc_pkg::REG_PC_ENABLE:   cfg_reg.pc_enable   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    pidpc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .stat(stat), .cmd(cmd)
    );

    pidpc_dp u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .cfg(cfg_reg), .stat(stat),
        .in_data(s_tdata), .in_flags(s_tuser),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_data(m_tdata), .out_flags(m_tuser)
    );
endmodule
`default_nettype wire
